FILE: rtl/f32f16_pkg.sv
// Package for the binary32/binary16 converter.
// Holds format constants and action codes; no dependencies.
package f32f16_pkg;
    localparam logic ACT_NARROW = 1'b0;
    localparam logic ACT_WIDEN  = 1'b1;

    localparam logic [15:0] H_INF      = 16'h7C00;
    localparam logic [31:0] F_INF      = 32'h7F80_0000;
    localparam logic [31:0] F_QNAN     = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_BIAS_D = 8'd112;
    localparam logic [7:0]  EXP_OVF    = 8'd143;
    localparam logic [7:0]  EXP_UNF    = 8'd102;
endpackage

FILE: rtl/float32_float16_converter.sv
// Top level: binary32/binary16 converter with input and result registers.
// Depends on f32f16_pkg and f32f16_core.
//
// channel  signals                         direction
// in       in_valid/in_ready, action, value_bits    request in
// out      out_valid/out_ready, result_bits         result out
//
// One item per cycle unless stalled; results pass both registers.
// rst_n clears the valid flags only.
// Each stage advances when the stage after it is empty or being drained,
// so a stalled result holds while the input stage may still fill.
module float32_float16_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [31:0] value_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_bits
);
    import f32f16_pkg::*;

    logic        v1_reg, v2_reg;
    logic        act_reg;
    logic [31:0] val_reg, res_reg, res_next;
    logic        adv2;

    assign adv2     = !v2_reg || out_ready;
    assign in_ready = !v1_reg || adv2;

    f32f16_core u_core (
        .action      (act_reg),
        .value_bits  (val_reg),
        .result_bits (res_next)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            act_reg <= action;
            val_reg <= value_bits;
        end
        if (adv2 && v1_reg)
            res_reg <= res_next;
    end

    assign out_valid   = v2_reg;
    assign result_bits = res_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_bits))
        else $error("result changed while stalled");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && adv2 |=> out_valid)
        else $error("result lost");
    a_nar: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && adv2 && act_reg == ACT_NARROW |=> result_bits[31:16] == 16'd0)
        else $error("upper half not zero");
endmodule

FILE: rtl/f32f16_core.sv
// Combinational conversion core for binary32 <-> binary16.
// Depends on f32f16_pkg.
module f32f16_core (
    input  logic        action,
    input  logic [31:0] value_bits,
    output logic [31:0] result_bits
);
    import f32f16_pkg::*;

    logic        s32;
    logic [7:0]  e32;
    logic [22:0] m32;
    logic [15:0] nar;
    logic [23:0] sub_m;
    logic [4:0]  sh;
    logic        s16;
    logic [4:0]  e16;
    logic [9:0]  m16;
    logic [31:0] wid;
    logic [3:0]  p;
    logic [9:0]  mn;

    assign s32 = value_bits[31];
    assign e32 = value_bits[30:23];
    assign m32 = value_bits[22:0];
    assign s16 = value_bits[15];
    assign e16 = value_bits[14:10];
    assign m16 = value_bits[9:0];
    // shift for subnormal output, 1..11 when exponent is 102..112
    assign sh  = 5'(8'd113 - e32);

    // narrowing path
    always_comb
    begin
        sub_m = {1'b1, m32} >> sh;
        if (e32 == 8'hFF)
            nar = {s32, 15'(H_INF)} | {6'd0, m32[22:13]};
        else if (e32 >= EXP_OVF)
            nar = {s32, 15'(H_INF)};
        else if (e32 < EXP_UNF)
            nar = {s32, 15'd0};
        else if (e32 <= EXP_BIAS_D)
            nar = {s32, 5'd0, sub_m[22:13]};
        else
            nar = {s32, 5'(e32 - EXP_BIAS_D), m32[22:13]};
    end

    // leading-one position of a subnormal binary16 mantissa
    always_comb
    begin
        p = 4'd0;
        for (int i = 0; i < 10; i++)
            if (m16[i])
                p = 4'(i);
        mn = m16 << (4'd10 - p);
    end

    // widening path
    always_comb
    begin
        if (e16 == 5'd0)
        begin
            if (m16 == 10'd0)
                wid = {s16, 31'd0};
            else
                wid = {s16, 8'(8'd103 + {4'd0, p}), mn, 13'd0};
        end
        else if (e16 == 5'd31)
        begin
            if (m16 != 10'd0)
                wid = {s16, 31'(F_QNAN)} | {9'd0, m16, 13'd0};
            else
                wid = {s16, 31'(F_INF)};
        end
        else
            wid = {s16, 8'({3'd0, e16} + EXP_BIAS_D), m16, 13'd0};
    end

    assign result_bits = (action == ACT_WIDEN) ? wid : {16'd0, nar};
endmodule

FILE: tb/tb_top.sv
// Testbench for float32_float16_converter: random and directed conversion requests,
// checked against a behavioral binary32/binary16 predictor in a scoreboard class.
// Depends on f32f16_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_top;
    import f32f16_pkg::*;

    // Scoreboard: predicts each conversion and checks results in order
    class conv_scoreboard;
        logic [31:0] pending_results[$];
        int          mismatch_count;
        int          stray_count;

        function logic [15:0] narrow_bits(logic [31:0] u);
            logic [15:0] s16;
            logic [7:0]  ex;
            logic [23:0] man;
            s16 = {u[31], 15'd0};
            ex  = u[30:23];
            man = {1'b0, u[22:0]};
            if (ex == 8'hFF)
                return s16 | H_INF | 16'(man[22:13]);
            if (ex >= EXP_OVF)
                return s16 | H_INF;
            if (ex <= EXP_BIAS_D)
            begin
                if (ex < EXP_UNF)
                    return s16;
                man = (man | 24'h80_0000) >> (8'd113 - ex);
                return s16 | 16'(man >> 13);
            end
            return s16 | {1'b0, 5'(ex - EXP_BIAS_D), 10'd0} | 16'(man[22:13]);
        endfunction

        function logic [31:0] widen_bits(logic [15:0] h);
            logic [31:0] s32;
            logic [4:0]  ex;
            logic [9:0]  man;
            int          p;
            s32 = {h[15], 31'd0};
            ex  = h[14:10];
            man = h[9:0];
            if (ex == 5'd0)
            begin
                if (man == 10'd0)
                    return s32;
                p = 9;
                while (p > 0 && man[p] == 1'b0)
                    p--;
                return s32 | (32'(p + 103) << 23) | ((32'(man) << (23 - p)) & 32'h7F_FFFF);
            end
            if (ex == 5'd31)
            begin
                if (man != 10'd0)
                    return s32 | F_QNAN | (32'(man) << 13);
                return s32 | F_INF;
            end
            return s32 | (32'(ex + 8'd112) << 23) | (32'(man) << 13);
        endfunction

        function void note_request(logic act, logic [31:0] v);
            if (act == ACT_NARROW)
                pending_results.push_back({16'd0, narrow_bits(v)});
            else
                pending_results.push_back(widen_bits(v[15:0]));
        endfunction

        function void check_result(logic [31:0] got);
            logic [31:0] want;
            if (pending_results.size() == 0)
            begin
                stray_count++;
                if (mismatch_count + stray_count <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want)
            begin
                mismatch_count++;
                if (mismatch_count + stray_count <= 10)
                    $display("result_bits mismatch: expected %h got %h", want, got);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = 1'b0;
    logic [31:0] value_bits = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] result_bits;

    conv_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    bit recv_hold;
    int cycle_count;
    bit stim_done;

    always #5 clk = ~clk;

    float32_float16_converter u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .value_bits(value_bits),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_bits(result_bits)
    );

    // Send one request; hold valid until accepted. Valid is left high on
    // return so a back-to-back request replaces it at the same falling edge.
    task automatic send_request(logic act, logic [31:0] v);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        value_bits <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(act, v);
        @(negedge clk);
    endtask

    // Random request biased toward exponent edges
    task automatic send_random();
        logic [31:0] v;
        logic        act;
        v   = $urandom();
        act = 1'($urandom_range(1, 0));
        case ($urandom_range(5, 0))
            0: v[30:23] = 8'($urandom_range(115, 99));
            1: v[30:23] = 8'($urandom_range(145, 140));
            2: v[30:23] = $urandom_range(1, 0) ? 8'hFF : 8'h00;
            3: v[14:10] = $urandom_range(1, 0) ? 5'h1F : 5'h00;
            default: ;
        endcase
        send_request(act, v);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Receiver: random stalls, plus an optional long hold-off
    always @(negedge clk)
    begin
        if (recv_hold)
            out_ready <= 1'b0;
        else
            out_ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(result_bits);
    end

    // Timeout watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 200000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Long receiver hold-off while the sender keeps offering requests
    initial
    begin
        recv_hold = 1'b0;
        wait (stim_done == 1'b0 && cycle_count > 300);
        @(negedge clk);
        recv_hold = 1'b1;
        repeat (60) @(negedge clk);
        recv_hold = 1'b0;
    end

    initial
    begin
        sb = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stim_done = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes and each special case
        send_request(ACT_NARROW, 32'h0000_0000);
        send_request(ACT_NARROW, 32'hFFFF_FFFF);
        send_request(ACT_NARROW, 32'h7F80_0001); // NaN with only low payload
        send_request(ACT_NARROW, 32'hFFC0_2000); // NaN keeps top bits
        send_request(ACT_NARROW, 32'h7F80_0000);
        send_request(ACT_NARROW, 32'h4780_0000); // overflow at exponent 143
        send_request(ACT_NARROW, 32'hC77F_FFFF); // largest normal-range
        send_request(ACT_NARROW, 32'h3300_0000); // exponent 102
        send_request(ACT_NARROW, 32'h32FF_FFFF); // below subnormal range
        send_request(ACT_NARROW, 32'h387F_FFFF); // exponent 112
        send_request(ACT_NARROW, 32'h3880_0000); // exponent 113
        send_request(ACT_NARROW, 32'h807F_FFFF); // binary32 subnormal
        send_request(ACT_WIDEN, 32'hFFFF_0000);  // upper half ignored
        send_request(ACT_WIDEN, 32'h0000_0001);
        send_request(ACT_WIDEN, 32'h0000_83FF);
        send_request(ACT_WIDEN, 32'h0000_0200);
        send_request(ACT_WIDEN, 32'h0000_7C00);
        send_request(ACT_WIDEN, 32'h0000_FC01);
        send_request(ACT_WIDEN, 32'h0000_7E00);
        send_request(ACT_WIDEN, 32'h0000_7BFF);
        send_request(ACT_WIDEN, 32'hFFFF_FFFF);
        send_request(ACT_WIDEN, 32'h0000_0400);
        wait_drained();

        // Random phases with changing idle mix
        send_idle_pct = 37; recv_idle_pct = 58;
        repeat (250) send_random();
        wait_drained(); // sender pause until all results are in
        send_idle_pct = 58; recv_idle_pct = 37;
        repeat (250) send_random();
        send_idle_pct = 0; recv_idle_pct = 0;
        repeat (250) send_random();
        stim_done = 1'b1;

        wait_drained();
        repeat (10) @(negedge clk);
        if (sb.mismatch_count == 0 && sb.stray_count == 0 && sb.pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
